>>> rtl/can_link_health_monitor_assert.svh
// ----------------------------------------------------------------------------
// can link health monitor assertion macros
// Concurrent assertion wrappers, empty when built for synthesis.
// ----------------------------------------------------------------------------
`ifndef CAN_LINK_HEALTH_MONITOR_ASSERT_SVH
`define CAN_LINK_HEALTH_MONITOR_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define CLHM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CLHM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define CLHM_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define CLHM_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

>>> rtl/clhm_pkg.sv
// ----------------------------------------------------------------------------
// clhm_pkg
// Types, register indexes and constants of the can link health monitor.
// ----------------------------------------------------------------------------
package clhm_pkg;

   typedef enum logic [1:0] {
      LINK_OK        = 2'd0,
      LINK_NO_FRAMES = 2'd1,
      LINK_NO_MATCH  = 2'd2
   } link_type;

   typedef enum logic [2:0] {
      HEALTH_OK          = 3'd0,
      HEALTH_NO_FRAMES   = 3'd1,
      HEALTH_STALE       = 3'd2,
      HEALTH_DECODE_BAD  = 3'd3,
      HEALTH_IMPLAUSIBLE = 3'd4
   } health_type;

   typedef enum logic [2:0] {
      CSR_NO_FRAMES_LIMIT  = 3'd0,
      CSR_LAG_LIMIT        = 3'd1,
      CSR_NO_MATCH_LIMIT   = 3'd2,
      CSR_LINK_WINDOW      = 3'd3,
      CSR_WINDOW_MAX       = 3'd4,
      CSR_IMPLAUSIBLE      = 3'd5,
      CSR_MIN_MATCH        = 3'd6,
      CSR_MIN_FRAMES_PROF  = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [31:0] now_ms;
      logic [31:0] last_frame_ms;
      logic [31:0] last_match_ms;
      logic [31:0] rx_total_count;
      logic [31:0] rx_match_count;
      logic [31:0] rx_dash_count;
      logic [31:0] oob_count;
      logic        edge_busy;
   } req_type;

   typedef struct packed {
      link_type    link_state;
      health_type  health;
      logic [31:0] quiet_ms;
      logic        redraw_request;
   } rsp_type;

   localparam logic [31:0] SKEW_TOLERANCE_MS = 32'd2000;
   localparam logic [31:0] HOLD_MIN_MS       = 32'd1000;
   localparam logic [31:0] EXIT_RECENT_MS    = 32'd300;
   localparam logic [31:0] EXIT_MIN_FRAMES   = 32'd2;
   localparam logic [31:0] NEVER_MS          = 32'hFFFF_FFFF;

   localparam logic [15:0] NO_FRAMES_LIMIT_RST = 16'd2000;
   localparam logic [15:0] LAG_LIMIT_RST       = 16'd1200;
   localparam logic [15:0] NO_MATCH_LIMIT_RST  = 16'd1500;
   localparam logic [15:0] LINK_WINDOW_RST     = 16'd1500;
   localparam logic [15:0] WINDOW_MAX_RST      = 16'd2000;
   localparam logic [7:0]  IMPLAUSIBLE_RST     = 8'd20;
   localparam logic [7:0]  MIN_MATCH_RST       = 8'd25;
   localparam logic [7:0]  MIN_FRAMES_PROF_RST = 8'd5;

   // time from then to now, with a short backward skew read as zero
   function automatic logic [31:0] elapsed_ms(input logic [31:0] now_v,
                                              input logic [31:0] then_v);
      logic [31:0] fwd;
      logic [31:0] back;
      fwd  = now_v - then_v;
      back = then_v - now_v;
      if (now_v >= then_v) begin
         elapsed_ms = fwd;
      end else if (back <= SKEW_TOLERANCE_MS) begin
         elapsed_ms = '0;
      end else begin
         elapsed_ms = fwd;
      end
   endfunction

endpackage

>>> rtl/can_link_health_monitor.sv
// ----------------------------------------------------------------------------
// can_link_health_monitor
// Judges link state and health class of a bus from periodic evaluation ticks.
//
//   channel  ports                               direction
//   req      req_valid req_stall req_data        in, one tick per request
//   rsp      rsp_valid rsp_stall rsp_data        out, one result per tick
//   csr      csr_valid csr_ready csr_index/wdata in, register writes
//
// A request is registered, then evaluated in one pass into the result
// register once the output is free: one request per cycle while rsp_stall is low.
// Window, base counters and class state update as the result is loaded.
// Synchronous reset clears all control state and restores register defaults.
// rsp_stall holds the result; req_stall rises only with both stages full.
// ----------------------------------------------------------------------------
`include "can_link_health_monitor_assert.svh"

module can_link_health_monitor
   import clhm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  req_type       req_data,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_type       rsp_data,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  csr_index_type csr_index,
   input  logic [15:0]   csr_wdata
);

   // configuration
   logic [15:0] no_frames_limit_ff, lag_limit_ff, no_match_limit_ff;
   logic [15:0] link_window_ff, window_max_ff;
   logic [7:0]  implausible_ff, min_match_ff, min_frames_prof_ff;

   // pipeline
   req_type     req_ff;
   logic        s1_valid_ff, s1_valid_in;
   rsp_type     rsp_ff, rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        out_free, load_out, accept_req;

   // monitor state
   logic [31:0] window_start_ff, window_start_in;
   logic [31:0] total_base_ff, total_base_in;
   logic [31:0] match_base_ff, match_base_in;
   logic [31:0] dash_base_ff, dash_base_in;
   logic [31:0] oob_base_ff, oob_base_in;
   link_type    link_now_ff, link_now_in;
   health_type  health_now_ff, health_now_in;
   logic [31:0] health_time_ff, health_time_in;

   // evaluation
   logic        heard_any, heard_match, silent, restart, judge;
   logic [31:0] frame_age, match_age;
   logic [31:0] ws1, tb1, db1;
   logic [31:0] tb2, mb2, ob2;
   logic [31:0] td1, dd1, win_frames, md, od;
   logic [34:0] od_x5, md_x4;
   link_type    desired;
   health_type  health_raw, health_new;
   logic        held, can_leave;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign load_out   = s1_valid_ff && out_free;
   assign req_stall  = s1_valid_ff && !out_free;
   assign accept_req = req_valid && !req_stall;
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   always_comb begin
      if (accept_req) begin
         s1_valid_in = 1'b1;
      end else if (load_out) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_comb begin
      heard_any   = req_ff.last_frame_ms != '0;
      heard_match = req_ff.last_match_ms != '0;
      frame_age   = heard_any ? elapsed_ms(req_ff.now_ms, req_ff.last_frame_ms) : NEVER_MS;
      match_age   = heard_match ? elapsed_ms(req_ff.now_ms, req_ff.last_match_ms) : NEVER_MS;
      silent      = !heard_any || (frame_age > {16'd0, no_frames_limit_ff});

      // window restart on an unstarted or overlong window
      restart = (window_start_ff == '0) ||
                ((req_ff.now_ms - window_start_ff) > {16'd0, window_max_ff});
      ws1 = restart ? req_ff.now_ms         : window_start_ff;
      tb1 = restart ? req_ff.rx_total_count : total_base_ff;
      db1 = restart ? req_ff.rx_dash_count  : dash_base_ff;

      judge = !silent && ((req_ff.now_ms - ws1) >= {16'd0, link_window_ff});
      td1   = req_ff.rx_total_count - tb1;
      dd1   = req_ff.rx_dash_count - db1;

      if (silent) begin
         desired = LINK_NO_FRAMES;
      end else if (judge) begin
         if (td1 == '0 && dd1 == '0) begin
            desired = LINK_NO_FRAMES;
         end else if (td1 >= {24'd0, min_frames_prof_ff} && dd1 == '0) begin
            desired = LINK_NO_MATCH;
         end else begin
            desired = LINK_OK;
         end
      end else begin
         desired = link_now_ff;
      end

      // a judgement restarts the window too
      if (restart || judge) begin
         window_start_in = req_ff.now_ms;
         tb2             = req_ff.rx_total_count;
         mb2             = req_ff.rx_match_count;
         dash_base_in    = req_ff.rx_dash_count;
         ob2             = req_ff.oob_count;
      end else begin
         window_start_in = window_start_ff;
         tb2             = total_base_ff;
         mb2             = match_base_ff;
         dash_base_in    = dash_base_ff;
         ob2             = oob_base_ff;
      end
      total_base_in = tb2;
      match_base_in = mb2;
      oob_base_in   = ob2;

      win_frames = req_ff.rx_total_count - tb2;
      md         = req_ff.rx_match_count - mb2;
      od         = req_ff.oob_count - ob2;
      od_x5      = {1'b0, od, 2'b00} + {3'b000, od};
      md_x4      = {1'b0, md, 2'b00};

      if (silent) begin
         health_raw = HEALTH_NO_FRAMES;
      end else if (frame_age > {16'd0, lag_limit_ff}) begin
         health_raw = HEALTH_STALE;
      end else if (match_age > {16'd0, no_match_limit_ff} || req_ff.edge_busy) begin
         health_raw = HEALTH_DECODE_BAD;
      end else if (od >= {24'd0, implausible_ff}) begin
         health_raw = HEALTH_IMPLAUSIBLE;
      end else if (md >= {24'd0, min_match_ff} && od_x5 > md_x4) begin
         health_raw = HEALTH_DECODE_BAD;
      end else begin
         health_raw = HEALTH_OK;
      end

      // no-frames exit hysteresis
      held      = (req_ff.now_ms - health_time_ff) < HOLD_MIN_MS;
      can_leave = (heard_any && frame_age <= EXIT_RECENT_MS) || win_frames >= EXIT_MIN_FRAMES;
      if (health_now_ff == HEALTH_NO_FRAMES && (held || !can_leave)) begin
         health_new = HEALTH_NO_FRAMES;
      end else begin
         health_new = health_raw;
      end

      link_now_in    = desired;
      health_now_in  = health_new;
      health_time_in = (health_new != health_now_ff) ? req_ff.now_ms : health_time_ff;

      rsp_in.link_state     = desired;
      rsp_in.health         = health_new;
      rsp_in.quiet_ms       = frame_age;
      rsp_in.redraw_request = (desired != link_now_ff) || (health_new != health_now_ff);
   end

   always_ff @(posedge clock) begin
      if (accept_req) begin
         req_ff <= req_data;
      end
      if (load_out) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         window_start_ff <= '0;
         total_base_ff   <= '0;
         match_base_ff   <= '0;
         dash_base_ff    <= '0;
         oob_base_ff     <= '0;
         link_now_ff     <= LINK_OK;
         health_now_ff   <= HEALTH_OK;
         health_time_ff  <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (load_out) begin
            window_start_ff <= window_start_in;
            total_base_ff   <= total_base_in;
            match_base_ff   <= match_base_in;
            dash_base_ff    <= dash_base_in;
            oob_base_ff     <= oob_base_in;
            link_now_ff     <= link_now_in;
            health_now_ff   <= health_now_in;
            health_time_ff  <= health_time_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         no_frames_limit_ff <= NO_FRAMES_LIMIT_RST;
         lag_limit_ff       <= LAG_LIMIT_RST;
         no_match_limit_ff  <= NO_MATCH_LIMIT_RST;
         link_window_ff     <= LINK_WINDOW_RST;
         window_max_ff      <= WINDOW_MAX_RST;
         implausible_ff     <= IMPLAUSIBLE_RST;
         min_match_ff       <= MIN_MATCH_RST;
         min_frames_prof_ff <= MIN_FRAMES_PROF_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_NO_FRAMES_LIMIT: no_frames_limit_ff <= csr_wdata;
            CSR_LAG_LIMIT:       lag_limit_ff       <= csr_wdata;
            CSR_NO_MATCH_LIMIT:  no_match_limit_ff  <= csr_wdata;
            CSR_LINK_WINDOW:     link_window_ff     <= csr_wdata;
            CSR_WINDOW_MAX:      window_max_ff      <= csr_wdata;
            CSR_IMPLAUSIBLE:     implausible_ff     <= csr_wdata[7:0];
            CSR_MIN_MATCH:       min_match_ff       <= csr_wdata[7:0];
            CSR_MIN_FRAMES_PROF: min_frames_prof_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // result classes mirror the stored state once loaded
   `CLHM_ASSERT_NEXT(a_rsp_matches_state, clock, reset, load_out,
      rsp_valid_ff && rsp_ff.link_state == link_now_ff && rsp_ff.health == health_now_ff,
      "result classes differ from stored state")
   `CLHM_ASSERT_NEXT(a_redraw_on_change, clock, reset, load_out,
      rsp_ff.redraw_request == ((link_now_ff != $past(link_now_ff)) ||
                                (health_now_ff != $past(health_now_ff))),
      "redraw strobe does not match a class change")
   `CLHM_ASSERT_NEXT(a_state_holds, clock, reset, !load_out,
      $stable(link_now_ff) && $stable(health_now_ff) && $stable(window_start_ff),
      "monitor state moved without a request")
   `CLHM_ASSERT_NOW(a_stall_cause, clock, reset, req_stall,
      s1_valid_ff && rsp_valid_ff && rsp_stall, "request stalled with room in the pipeline")

endmodule
